FILE: design/json_capability_mask_scanner_top_defines.svh
// Assertion macros shared by the capability mask scanner checkers
`ifndef JSON_CAPABILITY_MASK_SCANNER_TOP_DEFINES_SVH
`define JSON_CAPABILITY_MASK_SCANNER_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is high
`define JCMS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles
`define JCMS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/jcms_pkg.sv
// Types, character codes and token tables for the capability mask scanner
package jcms_pkg;

   localparam int NTOK       = 9;
   localparam int KEY_TOK    = 0;
   localparam int TEXT_CHARS = 16;
   localparam int TEXT_W     = 8 * TEXT_CHARS;

   typedef logic [7:0]      byte_type;
   typedef logic [3:0]      mask_type;
   typedef logic [3:0]      len_type;
   typedef logic [2:0]      skip_type;
   typedef logic [NTOK-1:0] tok_vec_type;

   // Decode state of the string being compared
   typedef struct packed {
      logic        nul_seen;
      len_type     length;
      tok_vec_type match;
   } str_state_type;

   typedef enum logic [3:0] {
      PH_SCAN,
      PH_KEY_STR,
      PH_KEY_ESC,
      PH_AFTER_KEY,
      PH_AFTER_COLON,
      PH_ARRAY,
      PH_VAL_STR,
      PH_VAL_ESC,
      PH_SKIP_ELEM,
      PH_DONE
   } phase_type;

   localparam str_state_type STR_RESET = '{nul_seen: 1'b0, length: '0, match: '1};

   localparam len_type  LEN_MAX    = 4'd15;
   localparam skip_type USKIP_LEN  = 3'd4;

   localparam byte_type CH_NUL     = 8'h00;
   localparam byte_type CH_BS      = 8'h08;
   localparam byte_type CH_TAB     = 8'h09;
   localparam byte_type CH_LF      = 8'h0A;
   localparam byte_type CH_VT      = 8'h0B;
   localparam byte_type CH_FF      = 8'h0C;
   localparam byte_type CH_CR      = 8'h0D;
   localparam byte_type CH_SPACE   = 8'h20;
   localparam byte_type CH_QUOTE   = 8'h22;
   localparam byte_type CH_COMMA   = 8'h2C;
   localparam byte_type CH_COLON   = 8'h3A;
   localparam byte_type CH_LBRACK  = 8'h5B;
   localparam byte_type CH_BSLASH  = 8'h5C;
   localparam byte_type CH_RBRACK  = 8'h5D;
   localparam byte_type CH_LOW_B   = 8'h62;
   localparam byte_type CH_LOW_F   = 8'h66;
   localparam byte_type CH_LOW_N   = 8'h6E;
   localparam byte_type CH_LOW_R   = 8'h72;
   localparam byte_type CH_LOW_T   = 8'h74;
   localparam byte_type CH_LOW_U   = 8'h75;

   // Token texts, right justified; entry 0 is the key
   localparam logic [TEXT_W-1:0] TOK_TEXT [NTOK] = '{
      "capabilities", "display.write", "input.read", "sensor.read",
      "rf.transceive", "display.*", "input.*", "sensor.*", "rf.*"
   };
   localparam len_type TOK_LEN [NTOK] = '{
      4'd12, 4'd13, 4'd10, 4'd11, 4'd13, 4'd9, 4'd7, 4'd8, 4'd4
   };
   localparam mask_type TOK_BIT [NTOK] = '{
      4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'h1, 4'h2, 4'h4, 4'h8
   };

   // Character idx of token t, counted from the start of the token
   function automatic byte_type tok_char(input int t, input len_type idx);
      logic [TEXT_W-1:0] aligned;
      aligned = TOK_TEXT[t] << (8 * (TEXT_CHARS - int'(TOK_LEN[t])));
      return aligned[8 * (TEXT_CHARS - 1 - int'(idx)) +: 8];
   endfunction

   function automatic logic is_ws(input byte_type c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
             (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic byte_type decode_escape(input byte_type e);
      byte_type d;
      case (e)
         CH_LOW_B: d = CH_BS;
         CH_LOW_F: d = CH_FF;
         CH_LOW_N: d = CH_LF;
         CH_LOW_R: d = CH_CR;
         CH_LOW_T: d = CH_TAB;
         default:  d = e;
      endcase
      return d;
   endfunction

   // Tokens fully matched by the string so far
   function automatic tok_vec_type token_hits(input str_state_type s);
      tok_vec_type h;
      for (int t = 0; t < NTOK; t++) begin
         h[t] = s.match[t] && (s.length == TOK_LEN[t]);
      end
      return h;
   endfunction

   // Capability bits of the matched value tokens
   function automatic mask_type value_bits(input str_state_type s);
      tok_vec_type h;
      mask_type    m;
      h = token_hits(s);
      m = '0;
      for (int t = 1; t < NTOK; t++) begin
         if (h[t]) begin
            m = m | TOK_BIT[t];
         end
      end
      return m;
   endfunction

endpackage

FILE: design/jcms_if.sv
// Valid/ready channel interfaces for document bytes and capability masks

interface jcms_req_if;
   logic                 valid;
   logic                 ready;
   jcms_pkg::byte_type   data_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jcms_rsp_if;
   logic                 valid;
   logic                 ready;
   jcms_pkg::mask_type   capability_mask;

   modport source (output valid, output capability_mask, input ready);
   modport sink   (input valid, input capability_mask, output ready);
endinterface

FILE: design/json_capability_mask_scanner_top.sv
// Scans a JSON document one byte per transaction and returns a capability mask on
// its last byte. The block takes one byte every clock cycle while it is not stalled:
// bytes go into an input register, the parser and the token compare update their
// state from it, and the mask of a document lands in the result register when its
// last byte leaves the input register. Bytes keep flowing while a result waits; only a
// last byte that finds the result register still full waits for it to drain.
module json_capability_mask_scanner_top (
   input  logic              clock,
   input  logic              reset,
   jcms_req_if.sink          req_chan,
   jcms_rsp_if.source        rsp_chan
);

   logic                in_valid_ff, in_valid_in;
   jcms_pkg::byte_type  in_byte_ff;
   logic                in_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   jcms_pkg::mask_type  rsp_mask_ff;
   logic                take;
   logic                emit;
   jcms_pkg::mask_type  mask_out;

   // Consume the held byte unless it ends a document and the result slot is busy
   assign take           = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   // Hold the next byte in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   jcms_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (take),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .emit      (emit),
      .mask_out  (mask_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold the result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_mask_ff <= mask_out;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.capability_mask = rsp_mask_ff;

endmodule

FILE: design/jcms_token_match.sv
// Incremental compare of one decoded character against all tokens
module jcms_token_match (
   input  jcms_pkg::str_state_type str_cur,
   input  jcms_pkg::byte_type      char_in,
   output jcms_pkg::str_state_type str_next
);

   // Narrow the candidate set and count the character
   always_comb begin
      str_next = str_cur;
      if (!str_cur.nul_seen) begin
         if (char_in == jcms_pkg::CH_NUL) begin
            str_next.nul_seen = 1'b1;
         end else begin
            for (int t = 0; t < jcms_pkg::NTOK; t++) begin
               if ((str_cur.length >= jcms_pkg::TOK_LEN[t]) ||
                   (jcms_pkg::tok_char(t, str_cur.length) != char_in)) begin
                  str_next.match[t] = 1'b0;
               end
            end
            if (str_cur.length != jcms_pkg::LEN_MAX) begin
               str_next.length = str_cur.length + 4'd1;
            end
         end
      end
   end

endmodule

FILE: design/jcms_core.sv
// Document parser state machine and capability mask accumulation
module jcms_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  jcms_pkg::byte_type   data_byte,
   input  logic                 last_byte,
   output logic                 emit,
   output jcms_pkg::mask_type   mask_out
);

   jcms_pkg::phase_type     phase_ff, phase_in;
   jcms_pkg::skip_type      uskip_ff, uskip_in;
   jcms_pkg::str_state_type str_ff, str_in, str_fed;
   jcms_pkg::mask_type      mask_ff, mask_in;
   logic                    feed;
   logic                    is_val;
   jcms_pkg::byte_type      feed_char;

   jcms_token_match u_match (
      .str_cur  (str_ff),
      .char_in  (feed_char),
      .str_next (str_fed)
   );

   // Next phase, string state and mask for the current byte
   always_comb begin
      phase_in  = phase_ff;
      uskip_in  = uskip_ff;
      str_in    = str_ff;
      mask_in   = mask_ff;
      feed      = 1'b0;
      feed_char = data_byte;
      is_val    = (phase_ff == jcms_pkg::PH_VAL_STR) || (phase_ff == jcms_pkg::PH_VAL_ESC);

      case (phase_ff)
         jcms_pkg::PH_SCAN: begin
            if (data_byte == jcms_pkg::CH_QUOTE) begin
               phase_in = jcms_pkg::PH_KEY_STR;
               uskip_in = '0;
               str_in   = jcms_pkg::STR_RESET;
            end
         end
         jcms_pkg::PH_KEY_STR, jcms_pkg::PH_VAL_STR: begin
            if (uskip_ff != '0) begin
               uskip_in = uskip_ff - 3'd1;
            end else if (data_byte == jcms_pkg::CH_BSLASH) begin
               phase_in = is_val ? jcms_pkg::PH_VAL_ESC : jcms_pkg::PH_KEY_ESC;
            end else if (data_byte == jcms_pkg::CH_QUOTE) begin
               if (is_val) begin
                  mask_in  = mask_ff | jcms_pkg::value_bits(str_ff);
                  phase_in = jcms_pkg::PH_ARRAY;
               end else if (str_ff.match[jcms_pkg::KEY_TOK] &&
                            (str_ff.length == jcms_pkg::TOK_LEN[jcms_pkg::KEY_TOK])) begin
                  phase_in = jcms_pkg::PH_AFTER_KEY;
               end else begin
                  phase_in = jcms_pkg::PH_SCAN;
               end
            end else begin
               feed = 1'b1;
            end
         end
         jcms_pkg::PH_KEY_ESC, jcms_pkg::PH_VAL_ESC: begin
            if (data_byte == jcms_pkg::CH_LOW_U) begin
               uskip_in = jcms_pkg::USKIP_LEN;
            end else begin
               feed      = 1'b1;
               feed_char = jcms_pkg::decode_escape(data_byte);
            end
            phase_in = is_val ? jcms_pkg::PH_VAL_STR : jcms_pkg::PH_KEY_STR;
         end
         jcms_pkg::PH_AFTER_KEY, jcms_pkg::PH_AFTER_COLON: begin
            if (!jcms_pkg::is_ws(data_byte)) begin
               if ((phase_ff == jcms_pkg::PH_AFTER_KEY) &&
                   (data_byte == jcms_pkg::CH_COLON)) begin
                  phase_in = jcms_pkg::PH_AFTER_COLON;
               end else if ((phase_ff == jcms_pkg::PH_AFTER_COLON) &&
                            (data_byte == jcms_pkg::CH_LBRACK)) begin
                  phase_in = jcms_pkg::PH_ARRAY;
               end else if (data_byte == jcms_pkg::CH_QUOTE) begin
                  phase_in = jcms_pkg::PH_KEY_STR;
                  uskip_in = '0;
                  str_in   = jcms_pkg::STR_RESET;
               end else begin
                  phase_in = jcms_pkg::PH_SCAN;
               end
            end
         end
         jcms_pkg::PH_ARRAY: begin
            if (jcms_pkg::is_ws(data_byte) || (data_byte == jcms_pkg::CH_COMMA)) begin
               phase_in = jcms_pkg::PH_ARRAY;
            end else if (data_byte == jcms_pkg::CH_RBRACK) begin
               phase_in = jcms_pkg::PH_DONE;
            end else if (data_byte == jcms_pkg::CH_QUOTE) begin
               phase_in = jcms_pkg::PH_VAL_STR;
               uskip_in = '0;
               str_in   = jcms_pkg::STR_RESET;
            end else begin
               phase_in = jcms_pkg::PH_SKIP_ELEM;
            end
         end
         jcms_pkg::PH_SKIP_ELEM: begin
            if (data_byte == jcms_pkg::CH_COMMA) begin
               phase_in = jcms_pkg::PH_ARRAY;
            end else if (data_byte == jcms_pkg::CH_RBRACK) begin
               phase_in = jcms_pkg::PH_DONE;
            end
         end
         jcms_pkg::PH_DONE: begin
            phase_in = jcms_pkg::PH_DONE;
         end
         default: begin
            phase_in = jcms_pkg::PH_SCAN;
         end
      endcase

      if (feed) begin
         str_in = str_fed;
      end

      // Count an element cut off by end of document
      mask_out = mask_in;
      if ((phase_in == jcms_pkg::PH_VAL_STR) || (phase_in == jcms_pkg::PH_VAL_ESC)) begin
         mask_out = mask_in | jcms_pkg::value_bits(str_in);
      end
      emit = step && last_byte;
   end

   // Advance on each byte; return to reset state after the last one
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff <= jcms_pkg::PH_SCAN;
         uskip_ff <= '0;
         str_ff   <= jcms_pkg::STR_RESET;
         mask_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         uskip_ff <= uskip_in;
         str_ff   <= str_in;
         mask_ff  <= mask_in;
      end
   end

endmodule

FILE: design/jcms_checker.sv
// Port-level checks for the capability mask scanner and their bind
`include "json_capability_mask_scanner_top_defines.svh"

module jcms_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input jcms_pkg::mask_type rsp_capability_mask
);

   `JCMS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_capability_mask)), "stalled result changed")

   `JCMS_ASSERT(a_ready_only_on_stall, clock, reset, (!req_ready) |-> (rsp_valid && !rsp_ready), "input stalled without a stalled result")

   `JCMS_ASSERT(a_ready_after_drain, clock, reset, (rsp_valid && rsp_ready && !req_ready) |=> req_ready, "input stayed blocked after the result drained")

   `JCMS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && req_ready), "reset left a result or a blocked input")

endmodule

bind json_capability_mask_scanner_top jcms_checker u_jcms_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_capability_mask (rsp_chan.capability_mask)
);
